### src/sam_pkg.sv
// shared constants of the stereo audio mixer
package sam_pkg;

  localparam int SQ_BITS    = 16;
  localparam int GAIN_BITS  = 8;
  localparam int BOOST_BITS = 4;
  localparam int OUT_BITS   = 16;
  localparam int DIVISOR    = 100;
  localparam int CLIP_MAX   = 32767;
  localparam int CLIP_MIN   = -32768;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SQ_GAIN    = 2'd0;
  localparam reg_idx_t REG_SYNTH_GAIN = 2'd1;
  localparam reg_idx_t REG_BOOST      = 2'd2;
  localparam reg_idx_t REG_LOWPASS    = 2'd3;

  localparam logic [GAIN_BITS-1:0]  RST_SQ_GAIN    = 8'd150;
  localparam logic [GAIN_BITS-1:0]  RST_SYNTH_GAIN = 8'd100;
  localparam logic [BOOST_BITS-1:0] RST_BOOST      = 4'd1;

  typedef logic [2:0] state_t;

endpackage

### src/stereo_audio_mixer.sv
// stereo audio mixer: percentage gains, one-pole low-pass, boost and 16-bit clip
//
//  port group | direction | handshake           | contents
//  in_*       | input     | in_valid / in_stall | square sample, synth left/right, frame end
//  out_*      | output    | out_valid/out_stall | mixed left/right, frame end
//  APB        | slave     | psel/penable/pready | four config registers at 4*i
//
// one word passes through the states in order: each of the three source terms takes a gain
// multiply and then a reciprocal multiply for the divide by 100; filter, two boost
// multiplies, hand-off and a return to idle follow.
// in_stall is high while a word is being worked on; a finished word waits in the output
// register, and the next word is taken meanwhile; a stalled full output holds the hand-off.
// synchronous active-low reset clears control state and filter history, loads config defaults
module stereo_audio_mixer #(
  parameter int SYNTH_SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sam_pkg::SQ_BITS-1:0]     in_square_sample,
  input  logic signed [SYNTH_SAMPLE_BITS-1:0]    in_synth_left,
  input  logic signed [SYNTH_SAMPLE_BITS-1:0]    in_synth_right,
  input  logic                                   in_frame_end_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [sam_pkg::OUT_BITS-1:0]    out_mixed_left,
  output logic signed [sam_pkg::OUT_BITS-1:0]    out_mixed_right,
  output logic                                   out_frame_end_out,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sam_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [sam_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic [sam_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                   pready
);
  import sam_pkg::*;

  localparam int W   = SYNTH_SAMPLE_BITS;
  // headroom so that the square term plus a synth term never wraps
  localparam int SW  = (W > SQ_BITS) ? W : SQ_BITS + 1;
  localparam int AW  = SW + 2;
  localparam int PW  = AW + GAIN_BITS + 1;
  // magnitude of source times gain fits in MB bits
  localparam int MB  = SW + 7;
  localparam int RW  = MB + 1;
  localparam int K   = MB + 7;
  localparam int PRW = MB + RW;

  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_MUL  = 3'd1;
  localparam state_t ST_DIV  = 3'd2;
  localparam state_t ST_FILT = 3'd3;
  localparam state_t ST_BST  = 3'd4;
  localparam state_t ST_DONE = 3'd5;

  // ceil(2^K / 100): exact floor division for every magnitude below 2^MB
  localparam logic [63:0]             RECIP_FULL = ((64'd1 << K) + 64'(DIVISOR) - 64'd1)
                                                   / 64'(DIVISOR);
  localparam logic [RW-1:0]           RECIP = RECIP_FULL[RW-1:0];
  localparam logic signed [PW-1:0]    P_MAX = PW'(CLIP_MAX);
  localparam logic signed [PW-1:0]    P_MIN = PW'(CLIP_MIN);

  // config registers
  logic [GAIN_BITS-1:0]  sq_gain_r, synth_gain_r;
  logic [BOOST_BITS-1:0] boost_r;
  logic                  lowpass_r;

  // sequencer and datapath
  state_t                state_r, state_nxt;
  logic [1:0]            sel_r, sel_nxt;
  logic signed [SQ_BITS-1:0] sq_r;
  logic signed [W-1:0]   sl_r, sr_r;
  logic                  fe_r;
  logic                  neg_r, neg_nxt;
  logic [MB-1:0]         mag_r;
  logic signed [AW-1:0]  base_r, acc_l_r, acc_r_r;
  logic signed [AW-1:0]  prev_l_r, prev_r_r;
  logic signed [OUT_BITS-1:0] res_l_r, res_r_r;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [OUT_BITS-1:0] out_l_r, out_r_r;
  logic                  out_fe_r;

  logic                  in_take, out_load, cfg_wr;
  logic signed [AW-1:0]  mul_a;
  logic [GAIN_BITS-1:0]  mul_b;
  logic signed [PW-1:0]  prod;
  logic [MB-1:0]         prod_mag;
  logic signed [OUT_BITS-1:0] prod_clip;
  logic [PRW-1:0]        recip_prod;
  logic [PRW-K-1:0]      quot;
  logic signed [AW-1:0]  term;
  logic signed [AW:0]    sum_l, sum_r;
  logic signed [AW-1:0]  filt_l, filt_r;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid & ~in_stall;
  assign out_load = (state_r == ST_DONE) & (~out_valid_r | ~out_stall);

  assign out_valid         = out_valid_r;
  assign out_mixed_left    = out_l_r;
  assign out_mixed_right   = out_r_r;
  assign out_frame_end_out = out_fe_r;

  // register read-back
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_SQ_GAIN:    prdata[GAIN_BITS-1:0]  = sq_gain_r;
      REG_SYNTH_GAIN: prdata[GAIN_BITS-1:0]  = synth_gain_r;
      REG_BOOST:      prdata[BOOST_BITS-1:0] = boost_r;
      REG_LOWPASS:    prdata[0]              = lowpass_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_gain_r    <= RST_SQ_GAIN;
      synth_gain_r <= RST_SYNTH_GAIN;
      boost_r      <= RST_BOOST;
      lowpass_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SQ_GAIN:    sq_gain_r    <= pwdata[GAIN_BITS-1:0];
        REG_SYNTH_GAIN: synth_gain_r <= pwdata[GAIN_BITS-1:0];
        REG_BOOST:      boost_r      <= pwdata[BOOST_BITS-1:0];
        REG_LOWPASS:    lowpass_r    <= pwdata[0];
      endcase
    end
  end

  // shared multiplier: source times gain, or channel (filtered if low-pass on) times boost
  always_comb begin
    mul_a = '0;
    mul_b = synth_gain_r;
    if (state_r == ST_BST) begin
      mul_a = (sel_r == 2'd0) ? acc_l_r : acc_r_r;
      mul_b = GAIN_BITS'(boost_r);
    end else begin
      case (sel_r)
        2'd0: begin
          mul_a = {{(AW-SQ_BITS){sq_r[SQ_BITS-1]}}, sq_r};
          mul_b = sq_gain_r;
        end
        2'd1:    mul_a = {{(AW-W){sl_r[W-1]}}, sl_r};
        default: mul_a = {{(AW-W){sr_r[W-1]}}, sr_r};
      endcase
    end
  end

  assign prod     = PW'(mul_a) * $signed({1'b0, mul_b});
  assign prod_mag = prod[PW-1] ? MB'(-prod) : prod[MB-1:0];

  always_comb begin
    if (prod > P_MAX)
      prod_clip = OUT_BITS'(CLIP_MAX);
    else if (prod < P_MIN)
      prod_clip = OUT_BITS'(CLIP_MIN);
    else
      prod_clip = prod[OUT_BITS-1:0];
  end

  // divide by 100 as a reciprocal multiply on the magnitude, sign put back after
  assign recip_prod = PRW'(mag_r) * PRW'(RECIP);
  assign quot       = recip_prod[PRW-1:K];
  assign term       = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // one-pole filter: floor of the mean with the previous value
  assign sum_l  = {prev_l_r[AW-1], prev_l_r} + {acc_l_r[AW-1], acc_l_r};
  assign sum_r  = {prev_r_r[AW-1], prev_r_r} + {acc_r_r[AW-1], acc_r_r};
  assign filt_l = sum_l[AW:1];
  assign filt_r = sum_r[AW:1];

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall)
      out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_MUL;
          sel_nxt   = 2'd0;
        end
      end
      ST_MUL: begin
        neg_nxt   = prod[PW-1];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sel_r == 2'd2) begin
          state_nxt = ST_FILT;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_FILT: begin
        sel_nxt   = 2'd0;
        state_nxt = ST_BST;
      end
      ST_BST: begin
        sel_nxt = sel_r + 1'b1;
        if (sel_r == 2'd1)
          state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_FILT && lowpass_r) begin
        prev_l_r <= filt_l;
        prev_r_r <= filt_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      sq_r <= in_square_sample;
      sl_r <= in_synth_left;
      sr_r <= in_synth_right;
      fe_r <= in_frame_end_in;
    end
    if (state_r == ST_MUL)
      mag_r <= prod_mag;
    if (state_r == ST_DIV) begin
      case (sel_r)
        2'd0:    base_r  <= term;
        2'd1:    acc_l_r <= base_r + term;
        default: acc_r_r <= base_r + term;
      endcase
    end
    if (state_r == ST_FILT && lowpass_r) begin
      acc_l_r <= filt_l;
      acc_r_r <= filt_r;
    end
    if (state_r == ST_BST) begin
      if (sel_r == 2'd0)
        res_l_r <= prod_clip;
      else
        res_r_r <= prod_clip;
    end
    if (out_load) begin
      out_l_r  <= res_l_r;
      out_r_r  <= res_r_r;
      out_fe_r <= fe_r;
    end
  end

`ifndef SYNTH
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_MUL && sel_r == 2'd0)
    else $error("accepted word did not start the square term");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mixed_left)
      && $stable(out_mixed_right) && $stable(out_frame_end_out))
    else $error("stalled output word changed");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILT && !lowpass_r |=> $stable(prev_l_r) && $stable(prev_r_r))
    else $error("filter history changed with the filter off");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid && state_r == ST_IDLE)
    else $error("finished word not presented");
`endif

endmodule

### tb/tb_top.sv
// self-checking testbench for the stereo audio mixer: predictor, scoreboard and drivers
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sam_pkg::*;

  localparam int SYNTH_BITS = 24;

  typedef logic signed [SQ_BITS-1:0]    sq_t;
  typedef logic signed [SYNTH_BITS-1:0] syn_t;
  typedef logic signed [OUT_BITS-1:0]   pcm_t;

  typedef struct {
    pcm_t left;
    pcm_t right;
    logic frame_end;
  } mix_word_t;

  // mixer predictor plus queue of mixed words still owed by the block
  class mix_scoreboard;
    logic [GAIN_BITS-1:0]  sq_gain;
    logic [GAIN_BITS-1:0]  synth_gain;
    logic [BOOST_BITS-1:0] boost;
    logic                  lowpass_on;
    logic signed [25:0]    hist_left;
    logic signed [25:0]    hist_right;
    mix_word_t             owed_mix[$];
    int                    errors;

    function new();
      sq_gain    = RST_SQ_GAIN;
      synth_gain = RST_SYNTH_GAIN;
      boost      = RST_BOOST;
      lowpass_on = 1'b0;
      hist_left  = '0;
      hist_right = '0;
      errors     = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
      case (idx)
        REG_SQ_GAIN:    sq_gain    = value[GAIN_BITS-1:0];
        REG_SYNTH_GAIN: synth_gain = value[GAIN_BITS-1:0];
        REG_BOOST:      boost      = value[BOOST_BITS-1:0];
        REG_LOWPASS:    lowpass_on = value[0];
        default: ;
      endcase
    endfunction

    function pcm_t sat16(longint v);
      if (v > CLIP_MAX) return pcm_t'(CLIP_MAX);
      if (v < CLIP_MIN) return pcm_t'(CLIP_MIN);
      return pcm_t'(v);
    endfunction

    function void note_word(sq_t sq, syn_t sl, syn_t sr, logic fe);
      longint    base;
      longint    l;
      longint    r;
      mix_word_t w;
      // signed division truncates toward zero
      base = (longint'(sq) * longint'(sq_gain)) / DIVISOR;
      l = base + (longint'(sl) * longint'(synth_gain)) / DIVISOR;
      r = base + (longint'(sr) * longint'(synth_gain)) / DIVISOR;
      if (lowpass_on) begin
        // arithmetic shift gives the floor of the average
        l = (longint'(hist_left) + l) >>> 1;
        r = (longint'(hist_right) + r) >>> 1;
        hist_left  = l[25:0];
        hist_right = r[25:0];
      end
      l = l * longint'(boost);
      r = r * longint'(boost);
      w.left      = sat16(l);
      w.right     = sat16(r);
      w.frame_end = fe;
      owed_mix.push_back(w);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_mix(pcm_t left, pcm_t right, logic fe);
      mix_word_t w;
      if (owed_mix.size() == 0) begin
        report_mismatch($sformatf("unexpected word l=%0d r=%0d fe=%b", left, right, fe));
        return;
      end
      w = owed_mix.pop_front();
      if (left !== w.left)
        report_mismatch($sformatf("left got %0d want %0d", left, w.left));
      if (right !== w.right)
        report_mismatch($sformatf("right got %0d want %0d", right, w.right));
      if (fe !== w.frame_end)
        report_mismatch($sformatf("frame end got %b want %b", fe, w.frame_end));
    endtask

    function int pending();
      return owed_mix.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  sq_t                      in_square_sample;
  syn_t                     in_synth_left;
  syn_t                     in_synth_right;
  logic                     in_frame_end_in;
  logic                     out_valid;
  logic                     out_stall;
  pcm_t                     out_mixed_left;
  pcm_t                     out_mixed_right;
  logic                     out_frame_end_out;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  mix_scoreboard mix_sb;
  bit            idle_on;
  int            stall_hold;

  stereo_audio_mixer #(
    .SYNTH_SAMPLE_BITS(SYNTH_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_square_sample (in_square_sample),
    .in_synth_left    (in_synth_left),
    .in_synth_right   (in_synth_right),
    .in_frame_end_in  (in_frame_end_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mixed_left   (out_mixed_left),
    .out_mixed_right  (out_mixed_right),
    .out_frame_end_out(out_frame_end_out),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check at the edge, then choose the stall for the next cycle
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        mix_sb.check_mix(out_mixed_left, out_mixed_right, out_frame_end_out);
      if (stall_hold > 0) begin
        stall_hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mix_sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // junk above the register width must be dropped by the block
  function automatic logic [APB_DATA_BITS-1:0] with_junk(int unsigned v, int w);
    logic [APB_DATA_BITS-1:0] junk;
    junk = ($urandom_range(0, 1) == 0) ? '0 : APB_DATA_BITS'($urandom);
    return (junk & ~((32'd1 << w) - 32'd1)) | APB_DATA_BITS'(v);
  endfunction

  task automatic set_config(input int unsigned sq_g, input int unsigned syn_g,
                            input int unsigned bst, input int unsigned lp);
    apb_write(REG_SQ_GAIN, with_junk(sq_g, GAIN_BITS));
    apb_write(REG_SYNTH_GAIN, with_junk(syn_g, GAIN_BITS));
    apb_write(REG_BOOST, with_junk(bst, BOOST_BITS));
    apb_write(REG_LOWPASS, with_junk(lp, 1));
  endtask

  task automatic send_word(input sq_t sq, input syn_t sl, input syn_t sr, input logic fe);
    in_valid         <= 1'b1;
    in_square_sample <= sq;
    in_synth_left    <= sl;
    in_synth_right   <= sr;
    in_frame_end_in  <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mix_sb.note_word(sq, sl, sr, fe);
  endtask

  function automatic syn_t pick_synth();
    int mode;
    mode = $urandom_range(0, 7);
    if (mode == 0) return ($urandom_range(0, 1) == 0) ? {1'b0, {(SYNTH_BITS-1){1'b1}}}
                                                      : {1'b1, {(SYNTH_BITS-1){1'b0}}};
    if (mode <= 2) return syn_t'(int'($urandom_range(0, 40000)) - 20000);
    return syn_t'($urandom);
  endfunction

  function automatic sq_t pick_square();
    int mode;
    mode = $urandom_range(0, 7);
    if (mode == 0) return ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
    if (mode <= 2) return sq_t'(int'($urandom_range(0, 4000)) - 2000);
    return sq_t'($urandom);
  endfunction

  task automatic run_phase(input int n_words);
    int gap;
    for (int i = 0; i < n_words; i++) begin
      send_word(pick_square(), pick_synth(), pick_synth(), 1'($urandom_range(0, 1)));
      if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender drops valid, waits for every owed word, then idles before returning
  task automatic drain();
    in_valid <= 1'b0;
    while (mix_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    mix_sb     = new();
    idle_on    = 1'b1;
    stall_hold = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_square_sample <= '0;
    in_synth_left    <= '0;
    in_synth_right   <= '0;
    in_frame_end_in  <= 1'b0;
    out_stall        <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: field extremes, saturation both ways, frame end both values
    send_word(16'sh0000, 24'sh000000, 24'sh000000, 1'b0);
    send_word(16'sh7fff, 24'sh000000, 24'sh000000, 1'b1);
    send_word(16'sh8000, 24'sh000000, 24'sh000000, 1'b0);
    send_word(16'sh0000, 24'sh7fffff, 24'sh800000, 1'b1);
    send_word(16'sh0000, 24'sh800000, 24'sh7fffff, 1'b0);
    send_word(16'sh7fff, 24'sh7fffff, 24'sh7fffff, 1'b1);
    send_word(16'sh8000, 24'sh800000, 24'sh800000, 1'b0);
    send_word(16'shffff, 24'shffffff, 24'sh000001, 1'b0);
    send_word(16'sh0001, 24'sh000063, 24'shffff9d, 1'b1);
    send_word(16'sh2000, 24'shffc000, 24'sh001234, 1'b0);
    run_phase(150);
    drain();

    // full gains, filter on, maximum boost; then the receiver holds off for a long stretch
    set_config(255, 255, 15, 1);
    send_word(16'sh7fff, 24'sh7fffff, 24'sh800000, 1'b1);
    send_word(16'sh8000, 24'sh800000, 24'sh7fffff, 1'b0);
    send_word(16'sh0000, 24'sh000000, 24'sh000000, 1'b0);
    send_word(16'shffff, 24'shffffff, 24'shfffffe, 1'b1);
    send_word(16'sh0003, 24'sh000007, 24'shfffff9, 1'b0);
    stall_hold = 200;
    run_phase(150);
    drain();

    // zero gains and zero boost
    set_config(0, 0, 0, 0);
    run_phase(100);
    drain();

    // filter on with unity boost, no idling
    idle_on = 1'b0;
    set_config(0, 100, 1, 1);
    run_phase(150);
    drain();

    // boost of zero while the filter history still moves
    idle_on = 1'b1;
    set_config(100, 0, 0, 1);
    run_phase(100);
    drain();

    // filter off: history must survive until it is switched back on
    set_config(1, 1, 1, 0);
    run_phase(60);
    drain();

    for (int p = 0; p < 5; p++) begin
      idle_on = (p % 2 == 0);
      set_config($urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 15), $urandom_range(0, 1));
      run_phase(140);
      drain();
    end

    // last part of the run with no idling on either side
    idle_on = 1'b0;
    set_config(255, 0, 15, 1);
    run_phase(150);
    drain();

    repeat (50) @(posedge clk);
    if (mix_sb.errors == 0 && mix_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
